// File: sv/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared widths, operation codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 16;
  localparam int TOT_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // capture the incoming word, restart the scan
    logic issue;   // read one slot at the scan address
    logic commit;  // write back, update totals, load the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic addr_last;  // scan address sits on the last slot
    logic out_free;   // result register can take a new word
  } status_t;

endpackage

// File: sv/lfu_cache_lookup_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache, lookup and insert
// Fully associative least-frequently-used key/value cache.
// ----------------------------------------------------------------------------
// A result word is loaded for each accepted item. The scan reads the key,
// value and use count of one slot per cycle from the single read port of the
// slot memories; the read pipe then drains, and the write-back updates the
// slots and totals and loads the result register. The block then returns to
// idle, so a new item is taken only once the previous one has been written
// back into the slots. The write-back holds while the previous result is still
// unclaimed; a result waiting in its own register does not keep the next item
// from entering. A lookup hit returns the stored value and bumps the slot's
// use count (saturating); a miss returns miss_value. An insert of an absent
// key fills the lowest free slot or, when full, replaces the slot with the
// lowest count, smallest key on ties. miss_value is written through the cfg
// port, which is ready only while no item is in progress.
module lfu_cache_lookup_insert #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] read_value,
  output logic        evicted,
  output logic [31:0] hit_total,
  output logic [31:0] request_total
);

  lfu_pkg::cmd_t    cmd;
  lfu_pkg::status_t status;

  // take a register write only between items
  assign cfg_ready = in_ready;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lfu_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .key           (key),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .read_value    (read_value),
    .evicted       (evicted),
    .hit_total     (hit_total),
    .request_total (request_total)
  );

endmodule

// File: sv/lfu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences one item: accept, scan every slot, drain the read pipe, commit.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lfu_pkg::status_t status,
  output lfu_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.addr_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the previous result has been taken
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/lfu_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache datapath
// Slot memories, valid bits, scan compare stage, totals and result register.
// ----------------------------------------------------------------------------
module lfu_dpath #(
  parameter int ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lfu_pkg::cmd_t            cmd,
  output lfu_pkg::status_t         status,
  input  logic                     cfg_valid,
  input  logic [31:0]              cfg_data,
  input  logic                     operation,
  input  logic [lfu_pkg::KEY_W-1:0] key,
  input  logic [lfu_pkg::VAL_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic [lfu_pkg::VAL_W-1:0] read_value,
  output logic                     evicted,
  output logic [lfu_pkg::TOT_W-1:0] hit_total,
  output logic [lfu_pkg::TOT_W-1:0] request_total
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // slot storage
  logic [lfu_pkg::KEY_W-1:0] key_mem [ENTRIES];
  logic [lfu_pkg::VAL_W-1:0] val_mem [ENTRIES];
  logic [lfu_pkg::CNT_W-1:0] cnt_mem [ENTRIES];
  logic [ENTRIES-1:0]        valid;

  // captured item
  lfu_pkg::op_t              item_op;
  logic [lfu_pkg::KEY_W-1:0] item_key;
  logic [lfu_pkg::VAL_W-1:0] item_val;

  // scan pipe
  logic [IDX_W-1:0]          addr;
  logic                      cmp_en;
  logic [IDX_W-1:0]          cmp_idx;
  logic [lfu_pkg::KEY_W-1:0] rd_key;
  logic [lfu_pkg::VAL_W-1:0] rd_val;
  logic [lfu_pkg::CNT_W-1:0] rd_cnt;

  // scan trackers
  logic                      found;
  logic [IDX_W-1:0]          match_idx;
  logic [lfu_pkg::VAL_W-1:0] match_val;
  logic [lfu_pkg::CNT_W-1:0] match_cnt;
  logic                      free_found;
  logic [IDX_W-1:0]          free_idx;
  logic                      vic_found;
  logic [IDX_W-1:0]          vic_idx;
  logic [lfu_pkg::KEY_W-1:0] vic_key;
  logic [lfu_pkg::CNT_W-1:0] vic_cnt;

  logic [31:0]               miss_value;

  // commit decode
  logic                      is_lookup;
  logic                      do_insert;
  logic                      cnt_wr;
  logic [IDX_W-1:0]          wr_idx;
  logic [lfu_pkg::CNT_W-1:0] wr_cnt;
  logic                      cmp_valid;
  logic                      vic_take;

  assign status.addr_last = (addr == IDX_LAST);
  assign status.out_free  = !out_valid || out_ready;

  assign is_lookup = (item_op == lfu_pkg::OP_LOOKUP);
  assign do_insert = cmd.commit && !is_lookup && !found;
  assign cnt_wr    = (cmd.commit && is_lookup && found) || do_insert;
  assign wr_idx    = is_lookup ? match_idx : (free_found ? free_idx : vic_idx);
  assign wr_cnt    = is_lookup ?
                     ((match_cnt == lfu_pkg::CNT_MAX) ? match_cnt
                                                      : match_cnt + lfu_pkg::CNT_ONE) :
                     lfu_pkg::CNT_ONE;

  assign cmp_valid = valid[cmp_idx];
  assign vic_take  = cmp_valid &&
                     (!vic_found || (rd_cnt < vic_cnt) ||
                      ((rd_cnt == vic_cnt) && (rd_key < vic_key)));

  // memories: one read at the scan address, one write at commit
  always_ff @(posedge clk) begin
    if (do_insert) begin
      key_mem[wr_idx] <= item_key;
    end
    if (cmd.issue) begin
      rd_key <= key_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      val_mem[wr_idx] <= item_val;
    end
    if (cmd.issue) begin
      rd_val <= val_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    if (cmd.issue) begin
      rd_cnt <= cnt_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (do_insert) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // item capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_op  <= lfu_pkg::op_t'(operation);
      item_key <= key;
      item_val <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.issue;
      if (cmd.start) begin
        addr <= '0;
      end else if (cmd.issue) begin
        addr <= addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      cmp_idx <= addr;
    end
  end

  // compare stage: first match, first free slot, lowest count / key victim
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      vic_found  <= 1'b0;
    end else if (cmp_en) begin
      if (cmp_valid && (rd_key == item_key) && !found) begin
        found     <= 1'b1;
        match_idx <= cmp_idx;
        match_val <= rd_val;
        match_cnt <= rd_cnt;
      end
      if (!cmp_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (vic_take) begin
        vic_found <= 1'b1;
        vic_idx   <= cmp_idx;
        vic_key   <= rd_key;
        vic_cnt   <= rd_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_value <= '0;
    end else if (cfg_valid) begin
      miss_value <= cfg_data;
    end
  end

  // totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total     <= '0;
      request_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (is_lookup) begin
          request_total <= request_total + 1'b1;
          if (found) begin
            hit_total <= hit_total + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit        <= found;
      read_value <= (is_lookup && found) ? match_val : miss_value;
      evicted    <= !is_lookup && !found && !free_found;
    end
  end

endmodule

// File: sv/lfu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache port checker
// Port-level properties of the cache, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hit,
  input logic evicted
);

  // a pending result word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // one item at a time: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready while an item is in progress");

  // an eviction only happens on an insert of an absent key
  a_evict_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit)
    else $error("eviction reported together with a hit");

  // hold the result flags while the word waits
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(hit) && $stable(evicted))
    else $error("result word changed while waiting");

endmodule

bind lfu_cache_lookup_insert lfu_checker u_lfu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .evicted   (evicted)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache lookup/insert testbench
// Drives lookups, inserts and miss-value writes through the valid/ready
// channels with random bursts and output stalls. A shadow LFU cache predicts
// every result word, and a checker compares each accepted word field by field
// in order. Directed words cover empty, full, duplicate and eviction cases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS     = 16;
  localparam int POOL_SIZE = 24;
  localparam int LIMIT     = 500000;

  typedef struct packed {
    logic                      hit;
    logic [lfu_pkg::VAL_W-1:0] read_value;
    logic                      evicted;
    logic [lfu_pkg::TOT_W-1:0] hit_total;
    logic [lfu_pkg::TOT_W-1:0] request_total;
  } lookup_word_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_LONG
  } sink_mode_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [31:0]               cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      operation = lfu_pkg::OP_LOOKUP;
  logic [lfu_pkg::KEY_W-1:0] key = '0;
  logic [lfu_pkg::VAL_W-1:0] value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      hit;
  logic [31:0]               read_value;
  logic                      evicted;
  logic [31:0]               hit_total;
  logic [31:0]               request_total;

  // shadow cache
  logic                      slot_valid [SLOTS];
  logic [lfu_pkg::KEY_W-1:0] slot_key   [SLOTS];
  logic [lfu_pkg::VAL_W-1:0] slot_value [SLOTS];
  logic [lfu_pkg::CNT_W-1:0] slot_uses  [SLOTS];
  logic [lfu_pkg::TOT_W-1:0] hits_seen = '0;
  logic [lfu_pkg::TOT_W-1:0] lookups_seen = '0;
  logic [lfu_pkg::VAL_W-1:0] miss_reg = '0;

  lookup_word_t              pending_results [$];
  int                        mismatch_count = 0;
  int                        cycle_count = 0;
  int                        burst_left = 0;
  sink_mode_t                sink_mode = SINK_OPEN;
  int                        sink_mode_left = 0;
  int                        sink_hold_left = 0;
  logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  lfu_cache_lookup_insert #(.ENTRIES(SLOTS)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .key           (key),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .read_value    (read_value),
    .evicted       (evicted),
    .hit_total     (hit_total),
    .request_total (request_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_uses[i]  = '0;
    end
  end

  // Advance the shadow cache by one word and queue the result it must give.
  function automatic void predict_cache_step(lfu_pkg::op_t op,
                                             logic [lfu_pkg::KEY_W-1:0] k,
                                             logic [lfu_pkg::VAL_W-1:0] v);
    int           slot;
    int           target;
    lookup_word_t w;
    slot   = -1;
    target = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && slot_valid[i] && slot_key[i] == k)
        slot = i;
    w.hit        = (slot >= 0);
    w.read_value = miss_reg;
    w.evicted    = 1'b0;
    if (op == lfu_pkg::OP_LOOKUP) begin
      lookups_seen++;
      if (slot >= 0) begin
        hits_seen++;
        if (slot_uses[slot] != lfu_pkg::CNT_MAX)
          slot_uses[slot]++;
        w.read_value = slot_value[slot];
      end
    end else if (slot < 0) begin
      for (int i = 0; i < SLOTS; i++)
        if (target < 0 && !slot_valid[i])
          target = i;
      if (target < 0) begin
        // full: lowest use count goes, smallest key on ties
        w.evicted = 1'b1;
        target = 0;
        for (int i = 1; i < SLOTS; i++)
          if (slot_uses[i] < slot_uses[target] ||
              (slot_uses[i] == slot_uses[target] && slot_key[i] < slot_key[target]))
            target = i;
      end
      slot_valid[target] = 1'b1;
      slot_key[target]   = k;
      slot_value[target] = v;
      slot_uses[target]  = lfu_pkg::CNT_ONE;
    end
    w.hit_total     = hits_seen;
    w.request_total = lookups_seen;
    pending_results.push_back(w);
  endfunction

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready)
      miss_reg = cfg_data;
    if (!rst && in_valid && in_ready)
      predict_cache_step(lfu_pkg::op_t'(operation), key, value);
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    lookup_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word expected none actual hit=%b value=%h", $time,
                 hit, read_value);
        mismatch_count++;
      end else begin
        w = pending_results.pop_front();
        compare_field("hit", 32'(w.hit), 32'(hit));
        compare_field("read_value", w.read_value, read_value);
        compare_field("evicted", 32'(w.evicted), 32'(evicted));
        compare_field("hit_total", w.hit_total, hit_total);
        compare_field("request_total", w.request_total, request_total);
      end
    end
  end

  // Output side: switch between always-ready, coin-flip and long stalls.
  always @(posedge clk) begin
    if (sink_mode_left == 0) begin
      sink_mode      = sink_mode_t'($urandom_range(0, 2));
      sink_mode_left = $urandom_range(50, 400);
    end else begin
      sink_mode_left--;
    end
    if (sink_mode == SINK_OPEN) begin
      out_ready <= 1'b1;
    end else if (sink_mode == SINK_COIN) begin
      out_ready <= ($urandom_range(0, 1) == 1);
    end else if (sink_hold_left == 0) begin
      sink_hold_left = $urandom_range(1, 25);
      out_ready <= !out_ready;
    end else begin
      sink_hold_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one word and hold it until taken; end the burst with a gap.
  task automatic send_word(input lfu_pkg::op_t op,
                           input logic [lfu_pkg::KEY_W-1:0] k,
                           input logic [lfu_pkg::VAL_W-1:0] v);
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    value     <= v;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end
  endtask

  // Drop valid and wait for every queued result word.
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_miss_value(input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_and_extremes;
    write_miss_value(32'hFFFF_FFFF);
    send_word(lfu_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0);
    send_word(lfu_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(lfu_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_word(lfu_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // duplicate insert must leave the stored value alone
    send_word(lfu_pkg::OP_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
    send_word(lfu_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0);
    send_word(lfu_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    drain_results();
  endtask

  task automatic test_fill_and_evict;
    write_miss_value(32'h0000_0000);
    for (int k = 1; k <= 14; k++)
      send_word(lfu_pkg::OP_INSERT, 32'(k), $urandom());
    // full now: key 1 is the smallest key among those with the lowest count
    send_word(lfu_pkg::OP_INSERT, 32'h8000_0000, $urandom());
    send_word(lfu_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0);
    drain_results();
  endtask

  task automatic test_random_mix;
    int                        insert_pct;
    logic [lfu_pkg::KEY_W-1:0] k;
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      unique case (phase)
        0:       write_miss_value(32'h0000_0000);
        1:       write_miss_value(32'hFFFF_FFFF);
        default: write_miss_value($urandom());
      endcase
      for (int i = 0; i < POOL_SIZE; i++)
        key_pool[i] = $urandom();
      insert_pct = $urandom_range(20, 80);
      for (int n = 0; n < 200; n++) begin
        if (phase == 3 && n == 100)
          drain_results();
        if ($urandom_range(0, 9) == 0)
          k = $urandom();
        else
          k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(1, 100) <= insert_pct)
          send_word(lfu_pkg::OP_INSERT, k, $urandom());
        else
          send_word(lfu_pkg::OP_LOOKUP, k, $urandom());
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_extremes();
    test_fill_and_evict();
    test_random_mix();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
